// ===== hdl/lrucc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU cache cost counter package
// Shared widths, constants, cell control type and state encoding.
// ----------------------------------------------------------------------------
package lrucc_pkg;

  localparam int KEY_W  = 64;
  localparam int COST_W = 32;
  localparam int CFG_W  = 6;

  // Bytes above this code are folded to upper case.
  localparam logic [7:0] FOLD_LIMIT  = 8'h5A;
  // Distance from a lower-case letter to its upper-case form.
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [COST_W-1:0] HIT_COST  = 32'd1;
  localparam logic [COST_W-1:0] MISS_COST = 32'd5;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic compare;  // capture the match result for the presented key
    logic update;   // move the recency order one place where selected
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Fold one character to upper case.
  function automatic logic [7:0] fold_byte(input logic [7:0] ch);
    fold_byte = (ch > FOLD_LIMIT) ? ch - CASE_OFFSET : ch;
  endfunction

endpackage

// ===== hdl/lrucc_ifs.sv =====
// ----------------------------------------------------------------------------
// LRU cache cost counter channels
// Valid/ready channels for lookup requests and cost responses.
// ----------------------------------------------------------------------------
interface lrucc_req_if import lrucc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_chars;

  modport source (output valid, output key_chars, input ready);
  modport sink   (input valid, input key_chars, output ready);
endinterface

interface lrucc_rsp_if import lrucc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [COST_W-1:0] total_cost;

  modport source (output valid, output hit, output total_cost, input ready);
  modport sink   (input valid, input hit, input total_cost, output ready);
endinterface

// ===== hdl/lrucc_cell.sv =====
// ----------------------------------------------------------------------------
// LRU cache cell
// One place of the recency-ordered key row: stores a key, compares it with
// the looked-up key, and takes its neighbour's key when the row moves.
// ----------------------------------------------------------------------------
module lrucc_cell import lrucc_pkg::*; #(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic [IW-1:0]    stop_idx,
  input  logic [KEY_W-1:0] prev_key,
  input  logic             prev_valid,
  output logic [KEY_W-1:0] key,
  output logic             valid,
  output logic             match
);

  logic take;

  // Every place up to and including the stop place takes its neighbour's entry.
  assign take = ctrl.update && (IW'(IDX) <= stop_idx);

  // Key storage; only read behind the valid bit.
  always_ff @(posedge clk) begin
    if (take) begin
      key <= prev_key;
    end
  end

  // Occupancy and match flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (take) begin
        valid <= prev_valid;
      end
      if (ctrl.compare) begin
        match <= valid && (key == cmp_key);
      end
    end
  end

endmodule

// ===== hdl/lru_cache_hit_cost_counter_top.sv =====
// ----------------------------------------------------------------------------
// LRU cache hit cost counter
// Fully associative LRU key cache held as a recency-ordered row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one key of packed ASCII characters (first character in the
//   top byte). rsp returns the hit flag and the running, saturating cost
//   (1 per hit, 5 per miss). cfg_we/cfg_wdata set the number of entries in
//   use; write it only while the block is idle. Zero turns the cache off.
// Timing:
//   A transfer on req is taken in the idle state; all cells compare the
//   folded key in that same cycle. In the update state, once rsp is free,
//   the row of cells moves its recency order by one place and the result
//   is registered into rsp. A new key is taken only once the previous
//   update is done. The pace is set by the compare-then-reorder of the
//   cell row.
// Stalls and reset:
//   While a response waits on rsp, one further key may be taken; its update
//   then holds until the waiting response is transferred.
//   Reset empties the cache, clears the cost and sets the size to zero.
// ----------------------------------------------------------------------------
module lru_cache_hit_cost_counter_top import lrucc_pkg::*; #(
  parameter int ENTRIES   = 32,
  parameter int KEY_CHARS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  lrucc_req_if.sink        req,
  lrucc_rsp_if.source      rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  state_t            state;
  state_t            state_next;
  logic [CFG_W-1:0]  cache_entries;
  logic [KEY_W-1:0]  key_fold;
  logic [KEY_W-1:0]  key_q;
  logic [CW-1:0]     count;
  logic [COST_W-1:0] cost_sum;
  logic              rsp_valid;
  logic              rsp_hit;

  logic              req_take;
  logic              rsp_free;
  logic              go;
  logic              cache_off;
  logic [LW-1:0]     limit;
  logic              grow;
  logic              hit;
  logic [IW-1:0]     hit_idx;
  logic [IW-1:0]     stop_idx;
  logic [COST_W:0]   cost_sum_wide;
  logic [COST_W-1:0] cost_add;
  cell_ctrl_t        ctrl;

  logic [KEY_W-1:0]  cell_key [ENTRIES];
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] cell_match;

  // Handshake qualifiers.
  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;

  // Fold the incoming key to upper case; unused low characters read as zero.
  always_comb begin
    key_fold = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < KEY_CHARS) begin
        key_fold[KEY_W-1-8*b -: 8] = fold_byte(req.key_chars[KEY_W-1-8*b -: 8]);
      end
    end
  end

  // Configuration register and the captured key.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_entries <= '0;
    end else if (cfg_we) begin
      cache_entries <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      key_q <= key_fold;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: compare on the request edge, reorder once the output is free.
  always_comb begin
    state_next   = state;
    ctrl.compare = 1'b0;
    go           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctrl.compare = req_take;
        if (req_take) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        go = rsp_free;
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // The row only moves while the cache is switched on.
    ctrl.update = go && !cache_off;
  end

  // Size in use, capped at the number of cells.
  always_comb begin
    limit = LW'(cache_entries);
    if (limit > LW'(ENTRIES)) begin
      limit = LW'(ENTRIES);
    end
  end

  assign cache_off = (cache_entries == '0);
  assign grow      = LW'(count) < limit;
  assign hit       = !cache_off && (|cell_match);

  // Place of the matching cell; at most one cell can match.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // Last place that moves: the hit, the first empty place, or the oldest entry.
  always_comb begin
    if (hit) begin
      stop_idx = hit_idx;
    end else if (grow) begin
      stop_idx = IW'(count);
    end else begin
      stop_idx = IW'(count - CW'(1));
    end
  end

  // Row of cells, most recent at place zero.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic             prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = key_q;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    lrucc_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .cmp_key    (key_fold),
      .stop_idx   (stop_idx),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .key        (cell_key[i]),
      .valid      (cell_valid[i]),
      .match      (cell_match[i])
    );
  end

  // Occupancy grows on a miss while below the size in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.update && !hit && grow) begin
      count <= count + CW'(1);
    end
  end

  // Running cost with saturation.
  assign cost_add      = hit ? HIT_COST : MISS_COST;
  assign cost_sum_wide = {1'b0, cost_sum} + {1'b0, cost_add};

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_sum <= '0;
    end else if (go) begin
      cost_sum <= cost_sum_wide[COST_W] ? '1 : cost_sum_wide[COST_W-1:0];
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      rsp_hit   <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
      rsp_hit   <= hit;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.total_cost = cost_sum;

  // A response appears only from the update state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_UPDATE))
    else $error("response raised outside the update state");

  // Occupied cells always form the count.
  assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell occupancy differs from the count");

  // Stored keys are unique, so at most one cell matches.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> $onehot0(cell_match))
    else $error("more than one cell matched");

  // The count never passes the number of cells.
  assert property (@(posedge clk) disable iff (rst)
    int'(count) <= ENTRIES)
    else $error("count beyond the number of cells");

endmodule
